>>> rtl/core/c2p_pkg.sv
// Shared constants for the cartesian-to-polar CORDIC pipeline.
// Angle table, gain constant and the phase format. No dependencies.
`timescale 1ns / 1ps

package c2p_pkg;

  localparam int DATA_WIDTH_DEF = 24;
  localparam int ITERATIONS_DEF = 16;

  // fraction bits appended to x and y ahead of the micro-rotations
  localparam int GUARD_BITS = 8;

  // angle accumulator: pi counts as 2^31
  localparam int Z_WIDTH = 34;
  localparam logic signed [Z_WIDTH-1:0] Z_PI = 34'sh0_8000_0000;
  localparam logic signed [Z_WIDTH-1:0] Z_ROUND = 34'sh0_0000_8000;

  // output phase: 32768 is pi
  localparam int PHASE_WIDTH = 17;
  localparam logic signed [PHASE_WIDTH-1:0] PHASE_PI = 17'sh08000;
  localparam logic signed [PHASE_WIDTH-1:0] PHASE_NEG_PI = -17'sh08000;

  // 1/K of the CORDIC gain, Q0.30
  localparam int GAIN_WIDTH = 30;
  localparam logic [GAIN_WIDTH-1:0] GAIN_Q30 = 30'd652032874;

  // gain multiply is split at this bit; the result drops MAG_SHIFT bits
  localparam int MUL_SPLIT = 20;
  localparam int MAG_SHIFT = 38;

  // round(atan(2^-i) * 2^31 / pi)
  localparam logic signed [Z_WIDTH-1:0] ATAN_TAB [32] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81,
    34'sd41,        34'sd20,        34'sd10,        34'sd5,
    34'sd3,         34'sd1,         34'sd1,         34'sd0
  };

endpackage

>>> rtl/core/cartesian_to_polar.sv
// Cartesian-to-polar converter: pipelined CORDIC in vectoring mode.
// Depends on c2p_pkg (angle table, gain, phase format).
// ---------------------------------------------------------------------------
// Usage:
//   Input: raise start with real_part/imag_part; the item is taken at any
//   rising edge where start is high and busy is low. busy is low except
//   while rst is high, so one item can enter on every clock.
//   Output: done pulses for one cycle with magnitude (unsigned, gain
//   compensated, saturating) and phase_angle (signed, 32768 = pi).
//   The receiver has no way to stall; results must be taken as they appear.
// Pipeline: after the accepting edge the item passes one input register,
//   one stage per micro-rotation, then two stages for the split gain
//   multiply and the rounding / clamping, before done is strobed.
// Throughput: one item per clock while rst is low, set by the fully pipelined rotations.
// Reset: rst (synchronous) clears all valid bits; items in flight are
//   dropped and no done pulse comes out of them.
// Zero imaginary part bypasses the rotation result: magnitude is |x| and the phase
//   is 0 or +pi.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cartesian_to_polar
  import c2p_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int ITERATIONS = ITERATIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [DATA_WIDTH-1:0]  real_part,
  input  logic signed [DATA_WIDTH-1:0]  imag_part,
  output logic                          done,
  output logic [DATA_WIDTH-1:0]         magnitude,
  output logic signed [PHASE_WIDTH-1:0] phase_angle
);

  // rotation datapath width: input, guard bits and CORDIC growth
  localparam int XW  = DATA_WIDTH + GUARD_BITS + 3;
  localparam int UXW = (XW - 1 > MUL_SPLIT) ? XW - 1 : MUL_SPLIT + 1;
  localparam int HW  = UXW - MUL_SPLIT;
  localparam int P1W = HW + GAIN_WIDTH;
  localparam int P2W = MUL_SPLIT + GAIN_WIDTH + 1;
  localparam int SW  = HW + GAIN_WIDTH + 1;
  localparam int LAT = ITERATIONS + 3;

  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // ---- input stage ----
  logic signed [XW-1:0] x_ext, y_ext, x_abs, y_adj;
  logic                 x_neg, y_pos, y_zero;

  always_comb begin
    x_ext  = XW'(real_part);
    y_ext  = XW'(imag_part);
    x_neg  = real_part[DATA_WIDTH-1];
    y_zero = (imag_part == '0);
    y_pos  = !imag_part[DATA_WIDTH-1] && !y_zero;
    x_abs  = x_neg ? -x_ext : x_ext;
    y_adj  = x_neg ? -y_ext : y_ext;
  end

  // rotation pipeline, one register stage per micro-rotation
  logic                        vld    [0:ITERATIONS];
  logic signed [XW-1:0]        x_p    [0:ITERATIONS];
  logic signed [XW-1:0]        y_p    [0:ITERATIONS];
  logic signed [Z_WIDTH-1:0]   z_p    [0:ITERATIONS];
  logic                        byp_p  [0:ITERATIONS];
  logic                        bneg_p [0:ITERATIONS];
  logic [DATA_WIDTH-1:0]       bmag_p [0:ITERATIONS];

  logic signed [XW-1:0]        x_nx   [0:ITERATIONS-1];
  logic signed [XW-1:0]        y_nx   [0:ITERATIONS-1];
  logic signed [Z_WIDTH-1:0]   z_nx   [0:ITERATIONS-1];

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
    logic rot_down;
    assign rot_down = !y_p[i][XW-1] && (y_p[i] != '0);
    assign x_nx[i] = rot_down ? x_p[i] + (y_p[i] >>> i) : x_p[i] - (y_p[i] >>> i);
    assign y_nx[i] = rot_down ? y_p[i] - (x_p[i] >>> i) : y_p[i] + (x_p[i] >>> i);
    assign z_nx[i] = rot_down ? z_p[i] + ATAN_TAB[i] : z_p[i] - ATAN_TAB[i];
  end

  // ---- gain multiply, split in two partial products ----
  logic                      m_vld;
  logic [P1W-1:0]            m_p1;
  logic [P2W-1:0]            m_p2;
  logic signed [Z_WIDTH-1:0] m_z;
  logic                      m_byp, m_bneg;
  logic [DATA_WIDTH-1:0]     m_bmag;

  logic [UXW-1:0]       ux;
  logic [HW-1:0]        ux_hi;
  logic [MUL_SPLIT-1:0] ux_lo;

  always_comb begin
    ux    = x_p[ITERATIONS][XW-1] ? '0 : UXW'(x_p[ITERATIONS][XW-2:0]);
    ux_hi = ux[UXW-1:MUL_SPLIT];
    ux_lo = ux[MUL_SPLIT-1:0];
  end

  // ---- final rounding, saturation and clamping ----
  logic [SW-1:0]             mag_sum;
  logic [DATA_WIDTH-1:0]     mag_val;
  logic signed [Z_WIDTH-1:0] z_rnd;
  logic signed [PHASE_WIDTH:0] ph_wide;
  logic signed [PHASE_WIDTH-1:0] ph_val;

  always_comb begin
    mag_sum = SW'(m_p1) + SW'(m_p2[P2W-1:MUL_SPLIT]);
    if (mag_sum[SW-1:MAG_SHIFT-MUL_SPLIT+DATA_WIDTH] != '0) begin
      mag_val = '1;
    end else begin
      mag_val = mag_sum[MAG_SHIFT-MUL_SPLIT+DATA_WIDTH-1:MAG_SHIFT-MUL_SPLIT];
    end
    z_rnd   = m_z + Z_ROUND;
    ph_wide = z_rnd[Z_WIDTH-1:16];
    if (ph_wide > (PHASE_WIDTH+1)'(PHASE_PI)) begin
      ph_val = PHASE_PI;
    end else if (ph_wide < (PHASE_WIDTH+1)'(PHASE_NEG_PI)) begin
      ph_val = PHASE_NEG_PI;
    end else begin
      ph_val = ph_wide[PHASE_WIDTH-1:0];
    end
  end

  // control: valid bits and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= ITERATIONS; k++) begin
        vld[k] <= 1'b0;
      end
      m_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      vld[0] <= accept;
      for (int k = 0; k < ITERATIONS; k++) begin
        vld[k+1] <= vld[k];
      end
      m_vld <= vld[ITERATIONS];
      done  <= m_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    x_p[0]    <= x_abs <<< GUARD_BITS;
    y_p[0]    <= y_adj <<< GUARD_BITS;
    z_p[0]    <= !x_neg ? '0 : (y_pos ? Z_PI : -Z_PI);
    byp_p[0]  <= y_zero;
    bneg_p[0] <= x_neg;
    bmag_p[0] <= x_abs[DATA_WIDTH-1:0];
    for (int k = 0; k < ITERATIONS; k++) begin
      x_p[k+1]    <= x_nx[k];
      y_p[k+1]    <= y_nx[k];
      z_p[k+1]    <= z_nx[k];
      byp_p[k+1]  <= byp_p[k];
      bneg_p[k+1] <= bneg_p[k];
      bmag_p[k+1] <= bmag_p[k];
    end
    m_p1   <= P1W'(ux_hi) * P1W'(GAIN_Q30);
    m_p2   <= P2W'(ux_lo) * P2W'(GAIN_Q30) + (P2W'(1) << (MAG_SHIFT - 1));
    m_z    <= z_p[ITERATIONS];
    m_byp  <= byp_p[ITERATIONS];
    m_bneg <= bneg_p[ITERATIONS];
    m_bmag <= bmag_p[ITERATIONS];
    if (m_byp) begin
      magnitude   <= m_bmag;
      phase_angle <= m_bneg ? PHASE_PI : '0;
    end else begin
      magnitude   <= mag_val;
      phase_angle <= ph_val;
    end
  end

  // ---- assertions ----
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result strobe without an accepted item");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (phase_angle <= PHASE_PI) && (phase_angle >= PHASE_NEG_PI))
    else $error("phase outside +-pi");

  a_zero_input: assert property (@(posedge clk) disable iff (rst)
    done && $past(real_part == '0 && imag_part == '0, LAT)
      |-> (magnitude == '0) && (phase_angle == '0))
    else $error("zero sample gave nonzero result");

  a_real_axis: assert property (@(posedge clk) disable iff (rst)
    done && $past(imag_part == '0, LAT)
      |-> (phase_angle == '0) || (phase_angle == PHASE_PI))
    else $error("real-axis sample gave off-axis phase");

endmodule
